// ===== rtl/core/iida_pkg.sv =====
// Shared definitions for the indexed insert/delete array block.
// Holds field widths, operation, status and register codes, the cell control
// struct and the small capacity divider. No dependencies.
package iida_pkg;

	// Field widths on the stream and configuration ports.
	localparam int FUNC_W     = 3;
	localparam int POS_W      = 5;
	localparam int VAL_W      = 32;
	localparam int STAT_W     = 2;
	localparam int CNT_OUT_W  = 5;
	localparam int CAP_W      = 7;
	localparam int GF_W       = 3;
	localparam int IC_W       = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Wide enough for any cell index or entry count up to the largest depth.
	localparam int CELL_POS_W = 11;

	// Default sizes of the store.
	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	localparam logic [CAP_W-1:0] CAP_MAX = 7'd127;

	// Operation codes carried by an input item.
	localparam logic [FUNC_W-1:0] FN_PUSH   = 3'd0;
	localparam logic [FUNC_W-1:0] FN_POP    = 3'd1;
	localparam logic [FUNC_W-1:0] FN_INSERT = 3'd2;
	localparam logic [FUNC_W-1:0] FN_DELETE = 3'd3;
	localparam logic [FUNC_W-1:0] FN_READ   = 3'd4;
	localparam logic [FUNC_W-1:0] FN_RELOAD = 3'd5;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_GROWTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_CAP  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_EN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_VAL  = 3'd3;

	// Per-cycle command broadcast to every cell.
	localparam logic [2:0] COP_HOLD   = 3'd0;
	localparam logic [2:0] COP_PUSH   = 3'd1;
	localparam logic [2:0] COP_INSERT = 3'd2;
	localparam logic [2:0] COP_DELETE = 3'd3;
	localparam logic [2:0] COP_FILL   = 3'd4;

	typedef struct packed {
		logic [2:0]            op;
		logic [CELL_POS_W-1:0] pos;
		logic [CELL_POS_W-1:0] lim;
	} cell_ctrl_t;

	// Capacity divided by a factor of 2 to 7, using reciprocal multiplies
	// that are exact for every 7-bit capacity.
	function automatic logic [CAP_W-1:0] cap_div(input logic [CAP_W-1:0] cap,
			input logic [GF_W-1:0] g);
		logic [14:0] p;
		logic [CAP_W-1:0] q;
		p = 15'(cap);
		unique case (g)
			3'd3: begin
				p = 15'(cap) * 15'd171;
				q = 7'(p >> 9);
			end
			3'd4: q = cap >> 2;
			3'd5: begin
				p = 15'(cap) * 15'd205;
				q = 7'(p >> 10);
			end
			3'd6: begin
				p = 15'(cap) * 15'd171;
				q = 7'(p >> 10);
			end
			3'd7: begin
				p = 15'(cap) * 15'd147;
				q = 7'(p >> 10);
			end
			default: q = p[CAP_W:1];
		endcase
		return q;
	endfunction

endpackage

// ===== rtl/core/indexed_insert_delete_array_top.sv =====
// Top level of the indexed insert/delete array: stream ports, configuration
// registers, count and capacity control and the chain of iida_cell entries.
// Depends on iida_pkg and iida_cell.
//
// Usage: each input transfer carries one operation (push, pop, insert,
// delete, read, reload) in s_axis_tuser with its position and value in
// s_axis_tdata. Each operation gives exactly one result transfer on the
// m_axis side with a status in m_axis_tuser and the read value, count,
// logical capacity and empty flag in m_axis_tdata.
// The result is registered: an accepted input waits in the execute stage
// and is written to the output register once that register is free. A new
// input is taken only while the single-entry execute stage is empty; that
// stage updates the whole cell chain and the count and capacity registers
// in the same cycle. Insert and delete move every later entry by one cell.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once
// and must only be made while no item is in flight.
// Reset: count 0, capacity 1, registers at their defaults, no result held.
// Entry contents are not cleared. When the receiver stalls, the result
// stays in the output register, one more item may be taken into the execute
// stage, and further input is held off until the result is transferred.
module indexed_insert_delete_array_top #(
	parameter int DEPTH      = iida_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = iida_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // position[4:0], element_value[36:5], zero pad
	input  logic [2:0]  s_axis_tuser,   // func[2:0]
	// Result stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // read_value[31:0], count[36:32],
	                                    // logical_capacity[43:37], is_empty_flag[44]
	output logic [1:0]  m_axis_tuser,   // status[1:0]
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [iida_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [iida_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CW    = (CNT_W > iida_pkg::POS_W) ? CNT_W : iida_pkg::POS_W;
	localparam int WW    = ((CW > iida_pkg::CAP_W) ? CW : iida_pkg::CAP_W) + 3;
	localparam int MW    = (DATA_WIDTH > iida_pkg::VAL_W) ? DATA_WIDTH : iida_pkg::VAL_W;
	localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);

	// Configuration registers.
	logic [iida_pkg::GF_W-1:0]  gf_q;
	logic [iida_pkg::IC_W-1:0]  ic_q;
	logic                       fe_q;
	logic [iida_pkg::VAL_W-1:0] fv_q;

	// Execute stage.
	logic                          valid_s1;
	logic [iida_pkg::FUNC_W-1:0]   func_s1;
	logic [iida_pkg::POS_W-1:0]    pos_s1;
	logic [iida_pkg::VAL_W-1:0]    val_s1;

	// Architectural state.
	logic [CNT_W-1:0]          cnt_q;
	logic [iida_pkg::CAP_W-1:0] cap_q;

	// Output register.
	logic                           m_valid_q;
	logic [iida_pkg::STAT_W-1:0]    status_q;
	logic [iida_pkg::VAL_W-1:0]     rd_q;
	logic [iida_pkg::CNT_OUT_W-1:0] cnt_out_q;
	logic [iida_pkg::CAP_W-1:0]     cap_out_q;
	logic                           empty_q;

	logic in_xfer;
	logic exec;

	// Decision logic.
	logic [iida_pkg::GF_W-1:0]  factor;
	logic [WW-1:0]              cnt_w;
	logic [WW-1:0]              cap_w;
	logic [WW-1:0]              pos_w;
	logic [WW-1:0]              ic_w;
	logic [WW-1:0]              fill_n;
	logic                       full;
	logic [9:0]                 cap_prod;
	logic [iida_pkg::CAP_W-1:0] cap_grown;
	logic [CNT_W-1:0]           cnt_dec;
	logic                       sparse;
	logic [iida_pkg::CAP_W-1:0] cap_quot;
	logic [iida_pkg::CAP_W-1:0] cap_shrunk;
	logic [iida_pkg::CAP_W-1:0] cap_reload;

	logic [iida_pkg::STAT_W-1:0] status_nx;
	logic [CNT_W-1:0]            cnt_nx;
	logic [iida_pkg::CAP_W-1:0]  cap_nx;
	logic [iida_pkg::VAL_W-1:0]  rd_nx;
	logic [2:0]                  cop;
	logic [CNT_W-1:0]            clim;
	logic [iida_pkg::VAL_W-1:0]  wr_val;

	// Cell chain.
	iida_pkg::cell_ctrl_t    cell_ctrl;
	logic [MW-1:0]           wr_mw;
	logic [DATA_WIDTH-1:0]   cell_wdata;
	logic [DATA_WIDTH-1:0]   cell_data [DEPTH];
	logic [DATA_WIDTH-1:0]   cell_rd;
	logic [MW-1:0]           rd_mw;

	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !valid_s1;
	assign exec          = valid_s1 && (!m_valid_q || m_axis_tready);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gf_q <= 3'd2;
			ic_q <= 5'd1;
			fe_q <= 1'b0;
			fv_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				iida_pkg::CFG_GROWTH:   gf_q <= cfg_wdata[iida_pkg::GF_W-1:0];
				iida_pkg::CFG_INIT_CAP: ic_q <= cfg_wdata[iida_pkg::IC_W-1:0];
				iida_pkg::CFG_FILL_EN:  fe_q <= cfg_wdata[0];
				iida_pkg::CFG_FILL_VAL: fv_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Execute stage valid: set on an input transfer, cleared when it runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (exec) begin
			valid_s1 <= 1'b0;
		end
	end

	// Execute stage payload.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_s1 <= s_axis_tuser;
			pos_s1  <= s_axis_tdata[4:0];
			val_s1  <= s_axis_tdata[36:5];
		end
	end

	// Shared arithmetic for growth, shrink and reload.
	always_comb begin
		factor    = (gf_q < 3'd2) ? 3'd2 : gf_q;
		cnt_w     = WW'(cnt_q);
		cap_w     = WW'(cap_q);
		pos_w     = WW'(pos_s1);
		ic_w      = WW'(ic_q);
		full      = cnt_w >= DEPTH_W;
		cap_prod  = 10'(cap_q) * 10'(factor);
		cap_grown = (cnt_w < cap_w) ? cap_q :
			((cap_prod > 10'(iida_pkg::CAP_MAX)) ? iida_pkg::CAP_MAX : cap_prod[6:0]);
		cnt_dec   = cnt_q - CNT_W'(1);
		sparse    = (cnt_dec == '0) || (cap_w >= WW'(cnt_dec) * WW'(factor));
		cap_quot  = iida_pkg::cap_div(cap_q, factor);
		cap_shrunk = (cap_quot == '0) ? 7'd1 : cap_quot;
		cap_reload = (ic_q == '0) ? 7'd1 : iida_pkg::CAP_W'(ic_q);
		fill_n    = (ic_w > DEPTH_W) ? DEPTH_W : ic_w;
	end

	// Read port of the chain, only used when the position is below the count.
	assign cell_rd = cell_data[pos_w[IDX_W-1:0]];
	assign rd_mw   = MW'(cell_rd);

	// Operation decode.
	always_comb begin
		status_nx = iida_pkg::ST_OK;
		cnt_nx    = cnt_q;
		cap_nx    = cap_q;
		rd_nx     = '0;
		cop       = iida_pkg::COP_HOLD;
		clim      = cnt_q;
		wr_val    = val_s1;
		unique case (func_s1)
			iida_pkg::FN_PUSH: begin
				if (full) begin
					status_nx = iida_pkg::ST_FULL;
				end else begin
					cap_nx = cap_grown;
					cnt_nx = cnt_q + CNT_W'(1);
					cop    = iida_pkg::COP_PUSH;
				end
			end
			iida_pkg::FN_POP: begin
				if (cnt_q == '0) begin
					status_nx = iida_pkg::ST_EMPTY;
				end else begin
					cnt_nx = cnt_dec;
					if (sparse) begin
						cap_nx = cap_shrunk;
					end
				end
			end
			iida_pkg::FN_INSERT: begin
				priority if (pos_w > cnt_w) begin
					status_nx = iida_pkg::ST_RANGE;
				end else if (full) begin
					status_nx = iida_pkg::ST_FULL;
				end else begin
					cap_nx = cap_grown;
					cnt_nx = cnt_q + CNT_W'(1);
					cop    = iida_pkg::COP_INSERT;
				end
			end
			iida_pkg::FN_DELETE: begin
				if (pos_w >= cnt_w) begin
					status_nx = iida_pkg::ST_RANGE;
				end else begin
					cnt_nx = cnt_dec;
					cop    = iida_pkg::COP_DELETE;
				end
			end
			iida_pkg::FN_READ: begin
				if (pos_w >= cnt_w) begin
					status_nx = iida_pkg::ST_RANGE;
				end else begin
					rd_nx = rd_mw[iida_pkg::VAL_W-1:0];
				end
			end
			iida_pkg::FN_RELOAD: begin
				cap_nx = cap_reload;
				if (fe_q) begin
					cnt_nx = CNT_W'(fill_n);
					clim   = CNT_W'(fill_n);
					wr_val = fv_q;
					cop    = iida_pkg::COP_FILL;
				end else begin
					cnt_nx = '0;
				end
			end
			default: ;
		endcase
	end

	// Command broadcast to the cells; only acts in the execute cycle.
	assign cell_ctrl.op  = exec ? cop : iida_pkg::COP_HOLD;
	assign cell_ctrl.pos = iida_pkg::CELL_POS_W'(pos_s1);
	assign cell_ctrl.lim = iida_pkg::CELL_POS_W'(clim);
	assign wr_mw         = MW'(wr_val);
	assign cell_wdata    = wr_mw[DATA_WIDTH-1:0];

	// Chain of cells, each linked to its neighbors.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end
		iida_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.INDEX     (i)
		) u_cell (
			.clk  (clk),
			.ctrl (cell_ctrl),
			.wdata(cell_wdata),
			.left (left_d),
			.right(right_d),
			.data (cell_data[i])
		);
	end

	// Count and capacity state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			cap_q <= 7'd1;
		end else if (exec) begin
			cnt_q <= cnt_nx;
			cap_q <= cap_nx;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (exec) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (exec) begin
			status_q  <= status_nx;
			rd_q      <= rd_nx;
			cnt_out_q <= cnt_nx[iida_pkg::CNT_OUT_W-1:0];
			cap_out_q <= cap_nx;
			empty_q   <= (cnt_nx == '0);
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {3'b000, empty_q, cap_out_q, cnt_out_q, rd_q};

endmodule

// ===== rtl/core/iida_cell.sv =====
// One storage cell of the entry chain: holds one entry and takes a new
// value from the write bus or from a neighbor. Depends on iida_pkg.
module iida_cell #(
	parameter int DATA_WIDTH = iida_pkg::DATA_WIDTH_DEF,
	parameter int INDEX      = 0
) (
	input  logic                   clk,
	input  iida_pkg::cell_ctrl_t   ctrl,
	input  logic [DATA_WIDTH-1:0]  wdata,
	input  logic [DATA_WIDTH-1:0]  left,
	input  logic [DATA_WIDTH-1:0]  right,
	output logic [DATA_WIDTH-1:0]  data
);

	localparam logic [iida_pkg::CELL_POS_W-1:0] ME = iida_pkg::CELL_POS_W'(INDEX);

	logic [DATA_WIDTH-1:0] data_q;

	// Each cell decides from its own position which source it loads.
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			iida_pkg::COP_PUSH: begin
				if (ME == ctrl.lim) begin
					data_q <= wdata;
				end
			end
			iida_pkg::COP_INSERT: begin
				if (ME == ctrl.pos) begin
					data_q <= wdata;
				end else if (ME > ctrl.pos && ME <= ctrl.lim) begin
					data_q <= left;
				end
			end
			iida_pkg::COP_DELETE: begin
				if (ME >= ctrl.pos) begin
					data_q <= right;
				end
			end
			iida_pkg::COP_FILL: begin
				if (ME < ctrl.lim) begin
					data_q <= wdata;
				end
			end
			default: data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

// ===== rtl/core/iida_checker.sv =====
// Port-level checks for the indexed insert/delete array top level,
// attached by the bind statement at the end. Depends on the top level ports.
module iida_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// No result is offered in the cycle after reset is seen held.
	a_no_result_in_reset: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("result offered during reset");

	// A stalled result holds its contents.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// The empty flag agrees with the reported count.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[44] |-> m_axis_tdata[36:32] == 5'd0)
		else $error("empty flag with nonzero count");

	// Logical capacity never reaches zero.
	a_cap_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[43:37] != 7'd0)
		else $error("zero logical capacity");

	// One item at a time: after an input transfer the block is busy.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is executing");

endmodule

bind indexed_insert_delete_array_top iida_checker u_iida_checker (.*);

// ===== bench/tb_indexed_insert_delete_array_top.sv =====
// Self-checking testbench for indexed_insert_delete_array_top: drives operation
// transfers and register writes, predicts every result and compares field by field.
// Depends on iida_pkg and the RTL of the block.
module tb_indexed_insert_delete_array_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Operation codes with no function; the block must answer them unchanged.
	localparam logic [iida_pkg::FUNC_W-1:0] FN_SPARE_A = 3'd6;
	localparam logic [iida_pkg::FUNC_W-1:0] FN_SPARE_B = 3'd7;
	// Register index past the end of the register list.
	localparam logic [iida_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

	localparam int STALL_LIMIT = 1000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 93;

	// Tracks the contents, count and capacity of the store and queues the
	// result each accepted operation must produce.
	class store_tracker_t;
		typedef struct {
			logic [iida_pkg::STAT_W-1:0] status;
			logic [iida_pkg::VAL_W-1:0]  value;
			logic [4:0]                  count;
			logic [iida_pkg::CAP_W-1:0]  capacity;
			logic                        empty;
		} result_t;

		logic [iida_pkg::VAL_W-1:0] cells[iida_pkg::DEPTH_DEF];
		int unsigned                n_entries = 0;
		int unsigned                cap = 1;
		logic [iida_pkg::GF_W-1:0]  growth = 3'd2;
		logic [iida_pkg::IC_W-1:0]  init_cap = 5'd1;
		logic                       fill_en = 1'b0;
		logic [iida_pkg::VAL_W-1:0] fill_word = '0;
		result_t                    due[$];
		int unsigned                errors = 0;

		function void set_reg(logic [iida_pkg::CFG_IDX_W-1:0] idx,
				logic [iida_pkg::CFG_DATA_W-1:0] data);
			unique case (idx)
				iida_pkg::CFG_GROWTH:   growth = data[iida_pkg::GF_W-1:0];
				iida_pkg::CFG_INIT_CAP: init_cap = data[iida_pkg::IC_W-1:0];
				iida_pkg::CFG_FILL_EN:  fill_en = data[0];
				iida_pkg::CFG_FILL_VAL: fill_word = data[iida_pkg::VAL_W-1:0];
				default: ;
			endcase
		endfunction

		// Capacity is multiplied when a successful push or insert finds it reached.
		function void grow(int unsigned g);
			if (n_entries >= cap) begin
				cap = (cap * g > iida_pkg::CAP_MAX) ? iida_pkg::CAP_MAX : cap * g;
			end
		endfunction

		function void note_op(logic [iida_pkg::FUNC_W-1:0] fn,
				logic [iida_pkg::POS_W-1:0] pos, logic [iida_pkg::VAL_W-1:0] val);
			result_t r;
			int unsigned g;
			int unsigned n;
			r.status = iida_pkg::ST_OK;
			r.value = '0;
			g = (growth < 2) ? 2 : growth;
			unique case (fn)
				iida_pkg::FN_PUSH: begin
					if (n_entries >= iida_pkg::DEPTH_DEF) begin
						r.status = iida_pkg::ST_FULL;
					end else begin
						grow(g);
						cells[n_entries] = val;
						n_entries++;
					end
				end
				iida_pkg::FN_POP: begin
					if (n_entries == 0) begin
						r.status = iida_pkg::ST_EMPTY;
					end else begin
						n_entries--;
						if (n_entries == 0 || cap >= g * n_entries) begin
							cap = cap / g;
							if (cap < 1) cap = 1;
						end
					end
				end
				iida_pkg::FN_INSERT: begin
					if (pos > n_entries) begin
						r.status = iida_pkg::ST_RANGE;
					end else if (n_entries >= iida_pkg::DEPTH_DEF) begin
						r.status = iida_pkg::ST_FULL;
					end else begin
						grow(g);
						for (int i = n_entries; i > pos; i--) cells[i] = cells[i-1];
						cells[pos] = val;
						n_entries++;
					end
				end
				iida_pkg::FN_DELETE: begin
					if (pos >= n_entries) begin
						r.status = iida_pkg::ST_RANGE;
					end else begin
						for (int i = pos; i + 1 < n_entries; i++) cells[i] = cells[i+1];
						n_entries--;
					end
				end
				iida_pkg::FN_READ: begin
					if (pos >= n_entries) r.status = iida_pkg::ST_RANGE;
					else r.value = cells[pos];
				end
				iida_pkg::FN_RELOAD: begin
					cap = (init_cap < 1) ? 1 : init_cap;
					if (fill_en) begin
						n = (init_cap > iida_pkg::DEPTH_DEF) ? iida_pkg::DEPTH_DEF : init_cap;
						for (int i = 0; i < n; i++) cells[i] = fill_word;
						n_entries = n;
					end else begin
						n_entries = 0;
					end
				end
				default: ;
			endcase
			r.count = n_entries[4:0];
			r.capacity = cap[iida_pkg::CAP_W-1:0];
			r.empty = (n_entries == 0);
			due = {due, r};
		endfunction

		function void check_result(logic [47:0] data, logic [iida_pkg::STAT_W-1:0] user);
			result_t r;
			if (due.size() == 0) begin
				$error("result transfer with no operation outstanding");
				errors++;
				return;
			end
			r = due.pop_front();
			if (user !== r.status) begin
				$error("status: expected %0d, got %0d", r.status, user);
				errors++;
			end
			if (data[31:0] !== r.value) begin
				$error("read_value: expected %h, got %h", r.value, data[31:0]);
				errors++;
			end
			if (data[36:32] !== r.count) begin
				$error("count: expected %0d, got %0d", r.count, data[36:32]);
				errors++;
			end
			if (data[43:37] !== r.capacity) begin
				$error("logical_capacity: expected %0d, got %0d", r.capacity, data[43:37]);
				errors++;
			end
			if (data[44] !== r.empty) begin
				$error("is_empty_flag: expected %0d, got %0d", r.empty, data[44]);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;   // position[4:0], element_value[36:5], zero pad
	logic [2:0]  s_axis_tuser = '0;   // func[2:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;        // read_value[31:0], count[36:32],
	                                  // logical_capacity[43:37], is_empty_flag[44]
	logic [1:0]  m_axis_tuser;        // status[1:0]
	logic        cfg_we = 1'b0;
	logic [iida_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [iida_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	store_tracker_t sb = new;
	bit             steady = 1'b0;
	int             quiet_cycles = 0;

	// Register settings of the random phases; the initial capacity extremes are present.
	int unsigned gf_tab[PHASES]   = '{2, 3, 4, 7, 1, 5, 6, 2, 4, 3};
	int unsigned ic_tab[PHASES]   = '{1, 0, 16, 31, 4, 2, 8, 15, 1, 3};
	bit          fill_tab[PHASES] = '{0, 1, 1, 0, 1, 1, 0, 1, 1, 0};

	indexed_insert_delete_array_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #1 clk = ~clk;

	// The receiver stalls at random except during the steady stretch.
	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= 22);
	end

	// Every result transfer is checked against the oldest prediction.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
	end

	// Watchdog on cycles without any transfer or register write.
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("indexed_insert_delete_array_top: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offers one operation, with random gaps ahead of it, until it is accepted.
	task automatic send_op(input logic [iida_pkg::FUNC_W-1:0] fn,
			input logic [iida_pkg::POS_W-1:0] pos, input logic [iida_pkg::VAL_W-1:0] val);
		while (!steady && $urandom_range(99) < 22) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, val, pos};
		s_axis_tuser <= fn;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_op(fn, pos, val);
	endtask

	// Stops offering input and waits until every predicted result has come back.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [iida_pkg::CFG_IDX_W-1:0] idx,
			input logic [iida_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	// Writes all registers with junk in the unused upper bits, plus a write
	// to an index beyond the register list that must be ignored.
	task automatic apply_settings(input int unsigned gf, input int unsigned ic,
			input bit fill, input logic [iida_pkg::VAL_W-1:0] fv);
		logic [31:0] junk;
		junk = $urandom;
		cfg_write(iida_pkg::CFG_GROWTH, {junk[31:3], gf[2:0]});
		cfg_write(iida_pkg::CFG_INIT_CAP, {junk[26:0], ic[4:0]});
		cfg_write(iida_pkg::CFG_FILL_EN, {junk[30:0], fill});
		cfg_write(iida_pkg::CFG_FILL_VAL, fv);
		cfg_write(CFG_SPARE, $urandom);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [iida_pkg::VAL_W-1:0] pick_value();
		unique case ($urandom_range(15))
			0: return 32'h0000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h8000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// One random operation; positions are mostly in range, sometimes anywhere.
	task automatic random_op();
		int unsigned r;
		logic [iida_pkg::FUNC_W-1:0] fn;
		logic [iida_pkg::POS_W-1:0]  pos;
		r = $urandom_range(99);
		if (r < 28) fn = iida_pkg::FN_PUSH;
		else if (r < 42) fn = iida_pkg::FN_POP;
		else if (r < 60) fn = iida_pkg::FN_INSERT;
		else if (r < 72) fn = iida_pkg::FN_DELETE;
		else if (r < 90) fn = iida_pkg::FN_READ;
		else if (r < 94) fn = iida_pkg::FN_RELOAD;
		else if (r < 97) fn = FN_SPARE_A;
		else fn = FN_SPARE_B;
		if ($urandom_range(9) < 2) begin
			pos = iida_pkg::POS_W'($urandom_range(31));
		end else if (fn == iida_pkg::FN_INSERT) begin
			pos = iida_pkg::POS_W'($urandom_range(sb.n_entries));
		end else if (sb.n_entries == 0) begin
			pos = '0;
		end else begin
			pos = iida_pkg::POS_W'($urandom_range(sb.n_entries - 1));
		end
		send_op(fn, pos, pick_value());
	endtask

	initial begin
		logic [iida_pkg::VAL_W-1:0] fv;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset settings: empty store, range errors, extreme
		// values, insert at the end, unused codes, shrinking pops, empty reload.
		send_op(iida_pkg::FN_POP, 5'd0, 32'h0);
		send_op(iida_pkg::FN_READ, 5'd0, 32'h0);
		send_op(iida_pkg::FN_DELETE, 5'd0, 32'h0);
		send_op(iida_pkg::FN_INSERT, 5'd1, 32'h1234_5678);
		send_op(iida_pkg::FN_PUSH, 5'd0, 32'h7fff_ffff);
		send_op(iida_pkg::FN_PUSH, 5'd31, 32'h8000_0000);
		send_op(iida_pkg::FN_INSERT, 5'd0, 32'hffff_ffff);
		send_op(iida_pkg::FN_INSERT, 5'd3, 32'h0000_0000);
		send_op(iida_pkg::FN_READ, 5'd0, 32'h0);
		send_op(iida_pkg::FN_READ, 5'd3, 32'h0);
		send_op(iida_pkg::FN_READ, 5'd4, 32'h0);
		send_op(iida_pkg::FN_DELETE, 5'd1, 32'h0);
		send_op(iida_pkg::FN_DELETE, 5'd31, 32'h0);
		send_op(FN_SPARE_A, 5'd31, 32'hffff_ffff);
		send_op(FN_SPARE_B, 5'd16, 32'h5555_aaaa);
		send_op(iida_pkg::FN_POP, 5'd0, 32'h0);
		send_op(iida_pkg::FN_POP, 5'd0, 32'h0);
		send_op(iida_pkg::FN_POP, 5'd0, 32'h0);
		send_op(iida_pkg::FN_RELOAD, 5'd0, 32'h0);
		settle();

		// Growth factor below two, filled reload to a full store, then a push and
		// an insert that must report the store full and one insert out of range.
		apply_settings(0, 16, 1'b1, 32'h8000_0000);
		send_op(iida_pkg::FN_RELOAD, 5'd0, 32'h0);
		send_op(iida_pkg::FN_PUSH, 5'd0, 32'h1);
		send_op(iida_pkg::FN_INSERT, 5'd0, 32'h2);
		send_op(iida_pkg::FN_INSERT, 5'd17, 32'h3);
		send_op(iida_pkg::FN_READ, 5'd15, 32'h0);
		send_op(iida_pkg::FN_DELETE, 5'd0, 32'h0);
		send_op(iida_pkg::FN_POP, 5'd0, 32'h0);
		settle();

		// Random phases, each under its own register settings.
		for (int p = 0; p < PHASES; p++) begin
			if (p == 4) fv = 32'h7fff_ffff;
			else if (p == 7) fv = 32'h8000_0000;
			else fv = $urandom;
			apply_settings(gf_tab[p], ic_tab[p], fill_tab[p], fv);
			steady = (p == 4);
			send_op(iida_pkg::FN_RELOAD, iida_pkg::POS_W'($urandom_range(31)), $urandom);
			repeat (PHASE_ITEMS) random_op();
			settle();
			steady = 1'b0;
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0) begin
			$display("indexed_insert_delete_array_top: match");
		end else begin
			$display("indexed_insert_delete_array_top: mismatch");
		end
		$finish;
	end

endmodule
